/* design/bbfa_pkg.sv */
package bbfa_pkg;

    localparam int MAX_ORDER_DEF       = 8;
    localparam int FRAME_COUNT_MAX_DEF = 65536;
    localparam int MAP_WORD_BITS_DEF   = 32;

    localparam int FUNC_W    = 2;
    localparam int COUNT_W   = 9;
    localparam int IDX_W     = 16;
    localparam int ORD_W     = 4;
    localparam int STATUS_W  = 2;
    localparam int TOTAL_W   = 17;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 17'd65536;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC_COUNT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC_NAMED = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FREE        = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        RES_DONE    = 2'd0,
        RES_NO_FREE = 2'd1,
        RES_BUSY    = 2'd2,
        RES_TOO_BIG = 2'd3
    } res_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_NAMED_RD,
        ST_NAMED_CHK,
        ST_MARK_LVL,
        ST_MARK_TEST,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_MARK_NEXT,
        ST_FREE_CHK,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_FREE_UP
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_SCAN_RD,
        OP_SCAN_NEXT,
        OP_SCAN_HIT,
        OP_NAMED_RD,
        OP_MARK_LVL,
        OP_MARK_RD,
        OP_MARK_WR,
        OP_NEXT_LVL,
        OP_FREE_RD,
        OP_FREE_WR,
        OP_FREE_UP
    } op_t;

    typedef struct packed {
        op_t  op;
        logic fin;
        res_t res;
        logic keep;
    } cmd_t;

    typedef struct packed {
        logic              clear_last;
        logic [FUNC_W-1:0] func;
        logic              order_big;
        logic              n_zero;
        logic              named_valid;
        logic              named_busy;
        logic              scan_hit;
        logic              scan_end;
        logic              lvl_empty;
        logic              word_last;
        logic              lvl_last;
        logic              pair_valid;
        logic              buddy_busy;
        logic              out_valid;
    } stat_t;

endpackage

/* design/bbfa_ctrl.sv */
module bbfa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  bbfa_pkg::stat_t st,
    output bbfa_pkg::cmd_t  cmd
);

    bbfa_pkg::state_t state_reg, state_next;
    logic can_fin;

    assign can_fin  = !st.out_valid;
    assign s_tready = (state_reg == bbfa_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bbfa_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bbfa_pkg::ST_CLEAR:
            begin
                if (st.clear_last)
                begin
                    state_next = bbfa_pkg::ST_IDLE;
                end
            end
            bbfa_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = bbfa_pkg::ST_DISPATCH;
                end
            end
            bbfa_pkg::ST_DISPATCH:
            begin
                if (st.func == bbfa_pkg::FUNC_ALLOC_COUNT && !st.order_big && !st.n_zero)
                begin
                    state_next = bbfa_pkg::ST_SCAN_RD;
                end
                else if (st.func == bbfa_pkg::FUNC_ALLOC_NAMED && !st.order_big)
                begin
                    state_next = st.named_valid ? bbfa_pkg::ST_NAMED_RD
                                                : bbfa_pkg::ST_MARK_LVL;
                end
                else if (st.func == bbfa_pkg::FUNC_FREE && !st.order_big)
                begin
                    state_next = bbfa_pkg::ST_FREE_CHK;
                end
                else if (can_fin)
                begin
                    state_next = bbfa_pkg::ST_IDLE;
                end
            end
            bbfa_pkg::ST_SCAN_RD:
            begin
                state_next = bbfa_pkg::ST_SCAN_CHK;
            end
            bbfa_pkg::ST_SCAN_CHK:
            begin
                if (st.scan_hit)
                begin
                    state_next = bbfa_pkg::ST_MARK_LVL;
                end
                else if (!st.scan_end)
                begin
                    state_next = bbfa_pkg::ST_SCAN_RD;
                end
                else if (can_fin)
                begin
                    state_next = bbfa_pkg::ST_IDLE;
                end
            end
            bbfa_pkg::ST_NAMED_RD:
            begin
                state_next = bbfa_pkg::ST_NAMED_CHK;
            end
            bbfa_pkg::ST_NAMED_CHK:
            begin
                if (!st.named_busy)
                begin
                    state_next = bbfa_pkg::ST_MARK_LVL;
                end
                else if (can_fin)
                begin
                    state_next = bbfa_pkg::ST_IDLE;
                end
            end
            bbfa_pkg::ST_MARK_LVL:
            begin
                state_next = bbfa_pkg::ST_MARK_TEST;
            end
            bbfa_pkg::ST_MARK_TEST:
            begin
                state_next = st.lvl_empty ? bbfa_pkg::ST_MARK_NEXT : bbfa_pkg::ST_MARK_RD;
            end
            bbfa_pkg::ST_MARK_RD:
            begin
                state_next = bbfa_pkg::ST_MARK_WR;
            end
            bbfa_pkg::ST_MARK_WR:
            begin
                state_next = st.word_last ? bbfa_pkg::ST_MARK_NEXT : bbfa_pkg::ST_MARK_RD;
            end
            bbfa_pkg::ST_MARK_NEXT:
            begin
                if (!st.lvl_last)
                begin
                    state_next = bbfa_pkg::ST_MARK_LVL;
                end
                else if (can_fin)
                begin
                    state_next = bbfa_pkg::ST_IDLE;
                end
            end
            bbfa_pkg::ST_FREE_CHK:
            begin
                if (st.pair_valid)
                begin
                    state_next = bbfa_pkg::ST_FREE_RD;
                end
                else if (!st.lvl_last)
                begin
                    state_next = bbfa_pkg::ST_FREE_UP;
                end
                else if (can_fin)
                begin
                    state_next = bbfa_pkg::ST_IDLE;
                end
            end
            bbfa_pkg::ST_FREE_RD:
            begin
                state_next = bbfa_pkg::ST_FREE_WR;
            end
            bbfa_pkg::ST_FREE_WR:
            begin
                if (!st.buddy_busy && !st.lvl_last)
                begin
                    state_next = bbfa_pkg::ST_FREE_UP;
                end
                else if (can_fin)
                begin
                    state_next = bbfa_pkg::ST_IDLE;
                end
            end
            bbfa_pkg::ST_FREE_UP:
            begin
                state_next = bbfa_pkg::ST_FREE_CHK;
            end
            default:
            begin
                state_next = bbfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.op   = bbfa_pkg::OP_NONE;
        cmd.res  = bbfa_pkg::RES_DONE;
        case (state_reg)
            bbfa_pkg::ST_CLEAR:
            begin
                cmd.op = bbfa_pkg::OP_CLEAR;
            end
            bbfa_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op = bbfa_pkg::OP_LOAD;
                end
            end
            bbfa_pkg::ST_DISPATCH:
            begin
                if (st.func == bbfa_pkg::FUNC_ALLOC_COUNT)
                begin
                    if (st.order_big)
                    begin
                        cmd.fin = can_fin;
                        cmd.res = bbfa_pkg::RES_TOO_BIG;
                    end
                    else if (st.n_zero)
                    begin
                        cmd.fin  = can_fin;
                        cmd.res  = bbfa_pkg::RES_NO_FREE;
                        cmd.keep = 1'b1;
                    end
                end
                else if (st.func == bbfa_pkg::FUNC_ALLOC_NAMED || st.func == bbfa_pkg::FUNC_FREE)
                begin
                    if (st.order_big)
                    begin
                        cmd.fin = can_fin;
                        cmd.res = bbfa_pkg::RES_NO_FREE;
                    end
                end
                else
                begin
                    cmd.fin = can_fin;
                    cmd.res = bbfa_pkg::RES_NO_FREE;
                end
            end
            bbfa_pkg::ST_SCAN_RD:
            begin
                cmd.op = bbfa_pkg::OP_SCAN_RD;
            end
            bbfa_pkg::ST_SCAN_CHK:
            begin
                if (st.scan_hit)
                begin
                    cmd.op = bbfa_pkg::OP_SCAN_HIT;
                end
                else if (!st.scan_end)
                begin
                    cmd.op = bbfa_pkg::OP_SCAN_NEXT;
                end
                else
                begin
                    cmd.fin  = can_fin;
                    cmd.res  = bbfa_pkg::RES_NO_FREE;
                    cmd.keep = 1'b1;
                end
            end
            bbfa_pkg::ST_NAMED_RD:
            begin
                cmd.op = bbfa_pkg::OP_NAMED_RD;
            end
            bbfa_pkg::ST_NAMED_CHK:
            begin
                if (st.named_busy)
                begin
                    cmd.fin  = can_fin;
                    cmd.res  = bbfa_pkg::RES_BUSY;
                    cmd.keep = 1'b1;
                end
            end
            bbfa_pkg::ST_MARK_LVL:
            begin
                cmd.op = bbfa_pkg::OP_MARK_LVL;
            end
            bbfa_pkg::ST_MARK_RD:
            begin
                cmd.op = bbfa_pkg::OP_MARK_RD;
            end
            bbfa_pkg::ST_MARK_WR:
            begin
                cmd.op = bbfa_pkg::OP_MARK_WR;
            end
            bbfa_pkg::ST_MARK_NEXT:
            begin
                if (!st.lvl_last)
                begin
                    cmd.op = bbfa_pkg::OP_NEXT_LVL;
                end
                else
                begin
                    cmd.fin  = can_fin;
                    cmd.keep = 1'b1;
                end
            end
            bbfa_pkg::ST_FREE_CHK:
            begin
                if (!st.pair_valid && st.lvl_last)
                begin
                    cmd.fin  = can_fin;
                    cmd.keep = 1'b1;
                end
            end
            bbfa_pkg::ST_FREE_RD:
            begin
                cmd.op = bbfa_pkg::OP_FREE_RD;
            end
            bbfa_pkg::ST_FREE_WR:
            begin
                // The clearing write is idempotent, so it repeats harmlessly while
                // the previous result still waits.
                cmd.op = bbfa_pkg::OP_FREE_WR;
                if (st.buddy_busy || st.lvl_last)
                begin
                    cmd.fin  = can_fin;
                    cmd.keep = 1'b1;
                end
            end
            bbfa_pkg::ST_FREE_UP:
            begin
                cmd.op = bbfa_pkg::OP_FREE_UP;
            end
            default:
            begin
                cmd.op = bbfa_pkg::OP_NONE;
            end
        endcase
    end

endmodule

/* design/bbfa_dp.sv */
module bbfa_dp #(
    parameter int MAX_ORDER       = bbfa_pkg::MAX_ORDER_DEF,
    parameter int FRAME_COUNT_MAX = bbfa_pkg::FRAME_COUNT_MAX_DEF,
    parameter int MAP_WORD_BITS   = bbfa_pkg::MAP_WORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bbfa_pkg::cmd_t                   cmd,
    output bbfa_pkg::stat_t                  st,
    input  logic [bbfa_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [bbfa_pkg::FUNC_W-1:0]      s_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bbfa_pkg::TOTAL_W-1:0]     cfg_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bbfa_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [bbfa_pkg::STATUS_W-1:0]    m_tuser
);

    localparam int W     = MAP_WORD_BITS;
    localparam int WB    = $clog2(MAP_WORD_BITS);
    localparam int LW    = $clog2(FRAME_COUNT_MAX + 1);
    localparam int IDW   = (LW > bbfa_pkg::IDX_W) ? LW : bbfa_pkg::IDX_W;
    localparam int HW    = IDW + MAX_ORDER + 1;
    localparam int CW    = (LW > bbfa_pkg::TOTAL_W) ? LW : bbfa_pkg::TOTAL_W;
    localparam int PW    = LW - WB;
    localparam int OW    = bbfa_pkg::ORD_W;

    function automatic int unsigned words_below(input int unsigned k);
        int unsigned acc;
        acc = 0;
        for (int unsigned i = 0; i <= MAX_ORDER; i++)
        begin
            if (i < k)
            begin
                acc += ((FRAME_COUNT_MAX >> i) + W - 1) >> WB;
            end
        end
        return acc;
    endfunction

    localparam int DEPTH = words_below(MAX_ORDER + 1);
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [AW-1:0] base_of(input logic [OW-1:0] k);
        int unsigned acc;
        acc = 0;
        for (int unsigned i = 0; i <= MAX_ORDER; i++)
        begin
            if (OW'(i) < k)
            begin
                acc += ((FRAME_COUNT_MAX >> i) + W - 1) >> WB;
            end
        end
        return AW'(acc);
    endfunction

    // Number of blocks of order k that have at least one frame below eff.
    function automatic logic [LW-1:0] lim_of(input logic [LW-1:0] e, input logic [OW-1:0] k);
        logic [CW+1:0] up;
        logic [CW+1:0] top;
        up  = ((CW + 2)'(e) + ((CW + 2)'(1) << k) - (CW + 2)'(1)) >> k;
        top = (CW + 2)'(FRAME_COUNT_MAX) >> k;
        return (up < top) ? LW'(up) : LW'(top);
    endfunction

    logic [W-1:0] mem [0:DEPTH-1];

    logic [bbfa_pkg::FUNC_W-1:0]   func_reg, func_next;
    logic [OW-1:0]                 kq_reg, kq_next;
    logic [OW-1:0]                 j_reg, j_next;
    logic [IDW-1:0]                id_reg, id_next;
    logic [IDW-1:0]                b_reg, b_next;
    logic [LW-1:0]                 lo_reg, lo_next;
    logic [LW-1:0]                 hi_reg, hi_next;
    logic [PW-1:0]                 wptr_reg, wptr_next;
    logic [AW-1:0]                 cptr_reg, cptr_next;
    logic [bbfa_pkg::TOTAL_W-1:0]  total_reg, total_next;
    logic                          ovalid_reg, ovalid_next;
    logic [bbfa_pkg::STATUS_W-1:0] ost_reg, ost_next;
    logic [bbfa_pkg::IDX_W-1:0]    oblk_reg, oblk_next;
    logic [OW-1:0]                 oord_reg, oord_next;
    logic [W-1:0]                  rdata_reg;

    logic [LW-1:0]      eff;
    logic [LW-1:0]      lim_k;
    logic [LW-1:0]      lim_j;
    logic [LW-1:0]      n_blk;
    logic [LW-1:0]      ws;
    logic [W-1:0]       scan_mask;
    logic [W-1:0]       mark_mask;
    logic [W-1:0]       free_bits;
    logic [WB-1:0]      first;
    logic [LW:0]        g;
    logic [OW-1:0]      kr;
    logic [HW-1:0]      lo_w, hi_w, lim_w;
    logic [LW-1:0]      hm1;
    logic [WB-1:0]      bpos;
    logic               bv, buv;
    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [W-1:0]       wr_data;

    logic [bbfa_pkg::COUNT_W-1:0] in_cnt;
    logic [bbfa_pkg::IDX_W-1:0]   in_idx;
    logic [OW-1:0]                in_ord;

    assign in_cnt = s_tdata[bbfa_pkg::COUNT_W-1:0];
    assign in_idx = s_tdata[bbfa_pkg::COUNT_W +: bbfa_pkg::IDX_W];
    assign in_ord = s_tdata[bbfa_pkg::COUNT_W + bbfa_pkg::IDX_W +: OW];

    assign eff   = ((CW)'(total_reg) > (CW)'(FRAME_COUNT_MAX)) ? LW'(FRAME_COUNT_MAX)
                                                                 : LW'(total_reg);
    assign lim_k = lim_of(eff, kq_reg);
    assign lim_j = lim_of(eff, j_reg);
    assign n_blk = eff >> kq_reg;
    assign ws    = {wptr_reg, {WB{1'b0}}};
    assign hm1   = hi_reg - LW'(1);
    assign bpos  = b_reg[WB-1:0];
    assign bv    = b_reg < IDW'(lim_j);
    assign buv   = (b_reg ^ IDW'(1)) < IDW'(lim_j);

    always_comb
    begin
        scan_mask = '0;
        mark_mask = '0;
        g         = '0;
        for (int p = 0; p < W; p++)
        begin
            g            = {1'b0, ws} + (LW + 1)'(p);
            scan_mask[p] = g < {1'b0, n_blk};
            mark_mask[p] = (g >= {1'b0, lo_reg}) && (g < {1'b0, hi_reg});
        end
    end

    assign free_bits = ~rdata_reg & scan_mask;

    always_comb
    begin
        first = '0;
        for (int p = W - 1; p >= 0; p--)
        begin
            if (free_bits[p])
            begin
                first = WB'(p);
            end
        end
    end

    // Rounded order of the frame count; one past the top when it cannot fit.
    always_comb
    begin
        kr = OW'(MAX_ORDER + 1);
        for (int i = MAX_ORDER; i >= 0; i--)
        begin
            if ((33'd1 << i) >= 33'(in_cnt))
            begin
                kr = OW'(i);
            end
        end
    end

    // Bit range of the block at level j: descendants below its order, the
    // single ancestor at and above it, clamped to the usable range.
    always_comb
    begin
        lim_w = HW'(lim_j);
        if (j_reg < kq_reg)
        begin
            lo_w = HW'(id_reg) << (kq_reg - j_reg);
            hi_w = (HW'(id_reg) + HW'(1)) << (kq_reg - j_reg);
        end
        else
        begin
            lo_w = HW'(id_reg) >> (j_reg - kq_reg);
            hi_w = lo_w + HW'(1);
        end
        if (lo_w > lim_w)
        begin
            lo_w = lim_w;
        end
        if (hi_w > lim_w)
        begin
            hi_w = lim_w;
        end
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = base_of(j_reg) + AW'(wptr_reg);
        wr_en   = 1'b0;
        wr_addr = base_of(j_reg) + AW'(wptr_reg);
        wr_data = rdata_reg | mark_mask;
        case (cmd.op)
            bbfa_pkg::OP_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = cptr_reg;
                wr_data = '0;
            end
            bbfa_pkg::OP_SCAN_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = base_of(kq_reg) + AW'(wptr_reg);
            end
            bbfa_pkg::OP_NAMED_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = base_of(kq_reg) + AW'(id_reg >> WB);
            end
            bbfa_pkg::OP_MARK_RD:
            begin
                rd_en = 1'b1;
            end
            bbfa_pkg::OP_MARK_WR:
            begin
                wr_en = 1'b1;
            end
            bbfa_pkg::OP_FREE_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = base_of(j_reg) + AW'(b_reg >> WB);
            end
            bbfa_pkg::OP_FREE_WR:
            begin
                wr_en   = bv;
                wr_addr = base_of(j_reg) + AW'(b_reg >> WB);
                wr_data = rdata_reg & ~(W'(1) << bpos);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        func_next   = func_reg;
        kq_next     = kq_reg;
        j_next      = j_reg;
        id_next     = id_reg;
        b_next      = b_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        wptr_next   = wptr_reg;
        cptr_next   = cptr_reg;
        total_next  = cfg_valid ? cfg_data : total_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ost_next    = ost_reg;
        oblk_next   = oblk_reg;
        oord_next   = oord_reg;
        case (cmd.op)
            bbfa_pkg::OP_CLEAR:
            begin
                cptr_next = cptr_reg + AW'(1);
            end
            bbfa_pkg::OP_LOAD:
            begin
                func_next = s_tuser;
                kq_next   = (s_tuser == bbfa_pkg::FUNC_ALLOC_COUNT) ? kr : in_ord;
                j_next    = (s_tuser == bbfa_pkg::FUNC_FREE) ? in_ord : '0;
                id_next   = IDW'(in_idx);
                b_next    = IDW'(in_idx);
                wptr_next = '0;
            end
            bbfa_pkg::OP_SCAN_NEXT:
            begin
                wptr_next = wptr_reg + PW'(1);
            end
            bbfa_pkg::OP_SCAN_HIT:
            begin
                id_next = IDW'(ws) + IDW'(first);
            end
            bbfa_pkg::OP_MARK_LVL:
            begin
                lo_next   = LW'(lo_w);
                hi_next   = LW'(hi_w);
                wptr_next = PW'(lo_w >> WB);
            end
            bbfa_pkg::OP_MARK_WR:
            begin
                wptr_next = wptr_reg + PW'(1);
            end
            bbfa_pkg::OP_NEXT_LVL:
            begin
                j_next = j_reg + OW'(1);
            end
            bbfa_pkg::OP_FREE_UP:
            begin
                b_next = b_reg >> 1;
                j_next = j_reg + OW'(1);
            end
            default:
            begin
                cptr_next = cptr_reg;
            end
        endcase
        if (cmd.fin)
        begin
            ovalid_next = 1'b1;
            ost_next    = cmd.res;
            oblk_next   = (cmd.res == bbfa_pkg::RES_DONE) ? id_reg[bbfa_pkg::IDX_W-1:0] : '0;
            oord_next   = cmd.keep ? kq_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cptr_reg   <= '0;
            total_reg  <= bbfa_pkg::TOTAL_RESET;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            cptr_reg   <= cptr_next;
            total_reg  <= total_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        kq_reg   <= kq_next;
        j_reg    <= j_next;
        id_reg   <= id_next;
        b_reg    <= b_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        wptr_reg <= wptr_next;
        ost_reg  <= ost_next;
        oblk_reg <= oblk_next;
        oord_reg <= oord_next;
    end

    always_comb
    begin
        st             = '0;
        st.clear_last  = cptr_reg == AW'(DEPTH - 1);
        st.func        = func_reg;
        st.order_big   = kq_reg > OW'(MAX_ORDER);
        st.n_zero      = n_blk == '0;
        st.named_valid = id_reg < IDW'(lim_k);
        st.named_busy  = rdata_reg[id_reg[WB-1:0]];
        st.scan_hit    = |free_bits;
        st.scan_end    = ({1'b0, ws} + (LW + 1)'(W)) >= {1'b0, n_blk};
        st.lvl_empty   = lo_reg >= hi_reg;
        st.word_last   = wptr_reg == hm1[LW-1:WB];
        st.lvl_last    = j_reg == OW'(MAX_ORDER);
        st.pair_valid  = bv || buv;
        st.buddy_busy  = buv && rdata_reg[bpos ^ WB'(1)];
        st.out_valid   = ovalid_reg;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = ovalid_reg;
    assign m_tuser   = ost_reg;
    assign m_tdata   = {{(bbfa_pkg::M_TDATA_W - bbfa_pkg::IDX_W - OW){1'b0}}, oord_reg, oblk_reg};

endmodule

/* design/bitmap_buddy_frame_allocator.sv */
// Buddy frame allocator with one busy bitmap per order, held in a single-port
// style word memory of MAP_WORD_BITS-bit words. After reset the block first runs
// a clearing pass that writes one word per cycle through the whole map;
// s_tready stays low during that pass, while configuration writes are taken at
// any time. Each request is handled on its own and gives one result beat. An
// allocate by count scans its order one bitmap word at a time, a read then a
// check for each word, then marks the block: for each order level from 0 to
// MAX_ORDER it sets up the range, tests it and steps on, reading and rewriting
// every bitmap word the marked range touches. A named allocate replaces the
// scan with one word read. A free climbs one level at a time through a check,
// a read, a clearing write and a step up. A finished result sits in an output
// register, so the next request is taken while the previous result waits for
// m_tready.
module bitmap_buddy_frame_allocator #(
    parameter int MAX_ORDER       = bbfa_pkg::MAX_ORDER_DEF,
    parameter int FRAME_COUNT_MAX = bbfa_pkg::FRAME_COUNT_MAX_DEF,
    parameter int MAP_WORD_BITS   = bbfa_pkg::MAP_WORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0 up: frame_count[8:0], block_index[24:9], block_order[28:25].
    input  logic [bbfa_pkg::S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0 up: func[1:0].
    input  logic [bbfa_pkg::FUNC_W-1:0]    s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0 up: granted_block[15:0], granted_order[19:16].
    output logic [bbfa_pkg::M_TDATA_W-1:0] m_tdata,
    // Fields from bit 0 up: status[1:0].
    output logic [bbfa_pkg::STATUS_W-1:0]  m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    // The total_frames register.
    input  logic [bbfa_pkg::TOTAL_W-1:0]   cfg_data
);

    bbfa_pkg::cmd_t  cmd;
    bbfa_pkg::stat_t st;

    // The controller sequences every request; the datapath owns the bitmap
    // memory, the request registers and the result register.
    bbfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    bbfa_dp #(
        .MAX_ORDER       (MAX_ORDER),
        .FRAME_COUNT_MAX (FRAME_COUNT_MAX),
        .MAP_WORD_BITS   (MAP_WORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
